// ===== src/rocket_recovery_deploy_fsm_assert.svh =====
// ----------------------------------------------------------------------------
// Recovery sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROCKET_RECOVERY_DEPLOY_FSM_ASSERT_SVH
`define ROCKET_RECOVERY_DEPLOY_FSM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Recovery sequencer package
// Field widths, phase codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

    localparam int ACCEL_W  = 16;
    localparam int ALT_W    = 21;
    localparam int TIME_W   = 32;
    localparam int MARGIN_W = 17;
    localparam int MS_W     = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 21;

    localparam logic [PHASE_W-1:0] PHASE_PAD    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_BOOST  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_COAST  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_APOGEE = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_MAIN   = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_TOUCH  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_ACCEL  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURNOUT_ACCEL = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_MARGIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FLIGHT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROGUE_PULSE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_ALT      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LANDING_ALT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMPACT_ACCEL  = 4'd7;

    localparam logic signed [ACCEL_W-1:0] LAUNCH_ACCEL_RST  = 16'sd1500;
    localparam logic signed [ACCEL_W-1:0] BURNOUT_ACCEL_RST = 16'sd500;
    localparam logic [MARGIN_W-1:0]       APOGEE_MARGIN_RST = 17'd50;
    localparam logic [MS_W-1:0]           MIN_FLIGHT_RST    = 16'd5000;
    localparam logic [MS_W-1:0]           DROGUE_PULSE_RST  = 16'd2000;
    localparam logic signed [ALT_W-1:0]   MAIN_ALT_RST      = 21'sd4500;
    localparam logic signed [ALT_W-1:0]   LANDING_ALT_RST   = 21'sd100;
    localparam logic signed [ACCEL_W-1:0] IMPACT_ACCEL_RST  = 16'sd2000;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] launch_accel;
        logic signed [ACCEL_W-1:0] burnout_accel;
        logic [MARGIN_W-1:0]       apogee_margin;
        logic [MS_W-1:0]           min_flight_time;
        logic [MS_W-1:0]           drogue_pulse_time;
        logic signed [ALT_W-1:0]   main_altitude;
        logic signed [ALT_W-1:0]   landing_altitude;
        logic signed [ACCEL_W-1:0] impact_accel;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/rrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Recovery sequencer configuration registers
// Holds the eight thresholds and timings, written one at a time by index.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0] wr_data,
    output rrd_pkg::cfg_t                       cfg
);
    import rrd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launch_accel      <= LAUNCH_ACCEL_RST;
            cfg_reg.burnout_accel     <= BURNOUT_ACCEL_RST;
            cfg_reg.apogee_margin     <= APOGEE_MARGIN_RST;
            cfg_reg.min_flight_time   <= MIN_FLIGHT_RST;
            cfg_reg.drogue_pulse_time <= DROGUE_PULSE_RST;
            cfg_reg.main_altitude     <= MAIN_ALT_RST;
            cfg_reg.landing_altitude  <= LANDING_ALT_RST;
            cfg_reg.impact_accel      <= IMPACT_ACCEL_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LAUNCH_ACCEL:  cfg_reg.launch_accel      <= wr_data[ACCEL_W-1:0];
                REG_BURNOUT_ACCEL: cfg_reg.burnout_accel     <= wr_data[ACCEL_W-1:0];
                REG_APOGEE_MARGIN: cfg_reg.apogee_margin     <= wr_data[MARGIN_W-1:0];
                REG_MIN_FLIGHT:    cfg_reg.min_flight_time   <= wr_data[MS_W-1:0];
                REG_DROGUE_PULSE:  cfg_reg.drogue_pulse_time <= wr_data[MS_W-1:0];
                REG_MAIN_ALT:      cfg_reg.main_altitude     <= wr_data[ALT_W-1:0];
                REG_LANDING_ALT:   cfg_reg.landing_altitude  <= wr_data[ALT_W-1:0];
                REG_IMPACT_ACCEL:  cfg_reg.impact_accel      <= wr_data[ACCEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/rrd_core.sv =====
// ----------------------------------------------------------------------------
// Recovery sequencer flight state machine
// Steps the flight phase once per sample and holds the deployment line state,
// which doubles as the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic signed [rrd_pkg::ACCEL_W-1:0] accel_z,
    input  wire logic signed [rrd_pkg::ALT_W-1:0]   altitude,
    input  wire logic [rrd_pkg::TIME_W-1:0]         now_ms,
    input  wire rrd_pkg::cfg_t                      cfg,
    output logic [rrd_pkg::PHASE_W-1:0]             flight_phase,
    output logic                                    drogue_fire,
    output logic                                    main_fire,
    output logic signed [rrd_pkg::ALT_W-1:0]        peak_altitude
);
    import rrd_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_PAD    = PHASE_PAD,
        PH_BOOST  = PHASE_BOOST,
        PH_COAST  = PHASE_COAST,
        PH_APOGEE = PHASE_APOGEE,
        PH_MAIN   = PHASE_MAIN,
        PH_TOUCH  = PHASE_TOUCH
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic signed [ALT_W-1:0] max_alt_reg, max_alt_next;
    logic [TIME_W-1:0]       launch_time_reg, launch_time_next;
    logic [TIME_W-1:0]       apogee_time_reg, apogee_time_next;
    logic                    drogue_reg, drogue_next;
    logic                    main_reg, main_next;

    logic [TIME_W-1:0]       since_apogee;
    logic [TIME_W-1:0]       since_launch;
    logic signed [ALT_W-1:0] peak;
    logic signed [ALT_W+1:0] alt_plus_margin;
    logic signed [ALT_W+1:0] peak_wide;

    always_comb
    begin
        since_apogee = now_ms - apogee_time_reg;
        since_launch = now_ms - launch_time_reg;
        peak = (altitude > max_alt_reg) ? altitude : max_alt_reg;
        alt_plus_margin = {{2{altitude[ALT_W-1]}}, altitude}
                        + $signed({6'd0, cfg.apogee_margin});
        peak_wide = {{2{peak[ALT_W-1]}}, peak};

        phase_next       = phase_reg;
        max_alt_next     = max_alt_reg;
        launch_time_next = launch_time_reg;
        apogee_time_next = apogee_time_reg;
        drogue_next      = drogue_reg;
        main_next        = main_reg;

        if (phase_reg inside {PH_APOGEE, PH_MAIN, PH_TOUCH}
            && since_apogee > {16'd0, cfg.drogue_pulse_time})
        begin
            drogue_next = 1'b0;
        end

        case (phase_reg)
            PH_PAD:
            begin
                if (accel_z > cfg.launch_accel)
                begin
                    phase_next       = PH_BOOST;
                    launch_time_next = now_ms;
                end
            end
            PH_BOOST:
            begin
                if (accel_z < cfg.burnout_accel)
                begin
                    phase_next = PH_COAST;
                end
            end
            PH_COAST:
            begin
                max_alt_next = peak;
                if (alt_plus_margin < peak_wide
                    && since_launch > {16'd0, cfg.min_flight_time})
                begin
                    phase_next       = PH_APOGEE;
                    apogee_time_next = now_ms;
                    drogue_next      = 1'b1;
                end
            end
            PH_APOGEE:
            begin
                if (altitude < cfg.main_altitude)
                begin
                    phase_next = PH_MAIN;
                    main_next  = 1'b1;
                end
            end
            PH_MAIN:
            begin
                if (altitude < cfg.landing_altitude || accel_z > cfg.impact_accel)
                begin
                    phase_next = PH_TOUCH;
                end
            end
            PH_TOUCH:
            begin
                main_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PAD;
            max_alt_reg     <= '0;
            launch_time_reg <= '0;
            apogee_time_reg <= '0;
            drogue_reg      <= 1'b0;
            main_reg        <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            max_alt_reg     <= max_alt_next;
            launch_time_reg <= launch_time_next;
            apogee_time_reg <= apogee_time_next;
            drogue_reg      <= drogue_next;
            main_reg        <= main_next;
        end
    end

    assign flight_phase  = phase_reg;
    assign drogue_fire   = drogue_reg;
    assign main_fire     = main_reg;
    assign peak_altitude = max_alt_reg;

endmodule

`default_nettype wire

// ===== src/rocket_recovery_deploy_fsm.sv =====
// ----------------------------------------------------------------------------
// Rocket recovery deployment sequencer
// Dual-deploy flight phase tracker with drogue and main line drive.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while in_stall is low and returns
// one result per sample: the sample lands in an input register, and the phase
// step then writes the flight state, which is also the result register, from
// which the result is presented. The update of that flight state sets the rate.
// A result waiting on out_stall holds the sample behind it in the input
// register, and in_stall rises once that register is full as well.
// Configuration writes are always taken and should be made only while no
// sample is in flight; there is no clearing pass after reset.
`default_nettype none

module rocket_recovery_deploy_fsm (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [rrd_pkg::ACCEL_W-1:0] accel_z,
    input  wire logic signed [rrd_pkg::ALT_W-1:0]   altitude,
    input  wire logic [rrd_pkg::TIME_W-1:0]         now_ms,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [rrd_pkg::PHASE_W-1:0]             flight_phase,
    output logic                                    drogue_fire,
    output logic                                    main_fire,
    output logic signed [rrd_pkg::ALT_W-1:0]        peak_altitude,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rrd_pkg::*;

    cfg_t                      cfg;
    logic                      in_valid_reg;
    logic                      out_valid_reg;
    logic signed [ACCEL_W-1:0] accel_reg;
    logic signed [ALT_W-1:0]   alt_reg;
    logic [TIME_W-1:0]         now_reg;
    logic                      out_free;
    logic                      advance;
    logic                      in_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            accel_reg <= accel_z;
            alt_reg   <= altitude;
            now_reg   <= now_ms;
        end
    end

    rrd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rrd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .accel_z       (accel_reg),
        .altitude      (alt_reg),
        .now_ms        (now_reg),
        .cfg           (cfg),
        .flight_phase  (flight_phase),
        .drogue_fire   (drogue_fire),
        .main_fire     (main_fire),
        .peak_altitude (peak_altitude)
    );

`include "rocket_recovery_deploy_fsm_assert.svh"

    `RRD_ASSERT_SAME(a_stall_only_when_full, in_stall,
        in_valid_reg && out_valid && out_stall,
        "input stalled without a blocked result")
    `RRD_ASSERT_SAME(a_main_phase, main_fire,
        flight_phase == PHASE_MAIN || flight_phase == PHASE_TOUCH,
        "main line driven outside main or touchdown")
    `RRD_ASSERT_SAME(a_drogue_phase, drogue_fire,
        flight_phase == PHASE_APOGEE || flight_phase == PHASE_MAIN
            || flight_phase == PHASE_TOUCH,
        "drogue line driven before apogee")
    `RRD_ASSERT_NEXT(a_result_follows, advance, out_valid, "stepped sample produced no result")

endmodule

`default_nettype wire

// ===== tb/rrd_flight_checker.sv =====
// ----------------------------------------------------------------------------
// Recovery sequencer flight checker
// Watches the sample, result and register channels of the sequencer, keeps
// its own copy of the flight state and limits, predicts one report per
// accepted sample and compares every result beat against the oldest report.
// ----------------------------------------------------------------------------
module rrd_flight_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [rrd_pkg::ACCEL_W-1:0] accel_z,
    input  logic signed [rrd_pkg::ALT_W-1:0]   altitude,
    input  logic [rrd_pkg::TIME_W-1:0]         now_ms,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [rrd_pkg::PHASE_W-1:0]        flight_phase,
    input  logic                               drogue_fire,
    input  logic                               main_fire,
    input  logic signed [rrd_pkg::ALT_W-1:0]   peak_altitude,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rrd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    typedef struct {
        logic [PHASE_W-1:0]      phase;
        logic                    drogue;
        logic                    main_line;
        logic signed [ALT_W-1:0] peak;
    } flight_report_t;

    cfg_t                    limits;
    logic [PHASE_W-1:0]      phase_r;
    logic signed [ALT_W-1:0] peak_r;
    logic [TIME_W-1:0]       launch_ms;
    logic [TIME_W-1:0]       apogee_ms;
    logic                    drogue_r;
    logic                    main_r;
    flight_report_t          report_q[$];

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LAUNCH_ACCEL:  limits.launch_accel      = data[ACCEL_W-1:0];
            REG_BURNOUT_ACCEL: limits.burnout_accel     = data[ACCEL_W-1:0];
            REG_APOGEE_MARGIN: limits.apogee_margin     = data[MARGIN_W-1:0];
            REG_MIN_FLIGHT:    limits.min_flight_time   = data[MS_W-1:0];
            REG_DROGUE_PULSE:  limits.drogue_pulse_time = data[MS_W-1:0];
            REG_MAIN_ALT:      limits.main_altitude     = data[ALT_W-1:0];
            REG_LANDING_ALT:   limits.landing_altitude  = data[ALT_W-1:0];
            REG_IMPACT_ACCEL:  limits.impact_accel      = data[ACCEL_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic advance_flight(input logic signed [ACCEL_W-1:0] accel,
                                  input logic signed [ALT_W-1:0] alt,
                                  input logic [TIME_W-1:0] now);
        logic signed [ACCEL_W-1:0] launch_lim;
        logic signed [ACCEL_W-1:0] burnout_lim;
        logic signed [ACCEL_W-1:0] impact_lim;
        logic signed [ALT_W-1:0]   main_lim;
        logic signed [ALT_W-1:0]   land_lim;
        logic [TIME_W-1:0]         since_launch;
        logic [TIME_W-1:0]         since_apogee;
        flight_report_t            rep;
        launch_lim   = limits.launch_accel;
        burnout_lim  = limits.burnout_accel;
        impact_lim   = limits.impact_accel;
        main_lim     = limits.main_altitude;
        land_lim     = limits.landing_altitude;
        since_launch = now - launch_ms;
        since_apogee = now - apogee_ms;

        if (phase_r inside {PHASE_APOGEE, PHASE_MAIN, PHASE_TOUCH} &&
            since_apogee > TIME_W'(limits.drogue_pulse_time))
            drogue_r = 1'b0;

        case (phase_r)
            PHASE_PAD:
            begin
                if (accel > launch_lim)
                begin
                    phase_r   = PHASE_BOOST;
                    launch_ms = now;
                end
            end
            PHASE_BOOST:
            begin
                if (accel < burnout_lim)
                    phase_r = PHASE_COAST;
            end
            PHASE_COAST:
            begin
                if (alt > peak_r)
                    peak_r = alt;
                if (longint'(alt) + longint'(limits.apogee_margin) < longint'(peak_r) &&
                    since_launch > TIME_W'(limits.min_flight_time))
                begin
                    phase_r   = PHASE_APOGEE;
                    apogee_ms = now;
                    drogue_r  = 1'b1;
                end
            end
            PHASE_APOGEE:
            begin
                if (alt < main_lim)
                begin
                    phase_r = PHASE_MAIN;
                    main_r  = 1'b1;
                end
            end
            PHASE_MAIN:
            begin
                if (alt < land_lim || accel > impact_lim)
                    phase_r = PHASE_TOUCH;
            end
            PHASE_TOUCH:
            begin
                main_r = 1'b0;
            end
            default:
            begin
            end
        endcase

        rep.phase     = phase_r;
        rep.drogue    = drogue_r;
        rep.main_line = main_r;
        rep.peak      = peak_r;
        report_q.push_back(rep);
    endtask

    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    task automatic check_report();
        flight_report_t rep;
        if (report_q.size() == 0)
        begin
            $display("%0t: result beat with no sample pending, phase %0d peak %0d",
                     $time, flight_phase, peak_altitude);
            fail_count++;
        end
        else
        begin
            rep = report_q.pop_front();
            check_field("flight_phase", rep.phase, flight_phase);
            check_field("drogue_fire", rep.drogue, drogue_fire);
            check_field("main_fire", rep.main_line, main_fire);
            check_field("peak_altitude", rep.peak, peak_altitude);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits = '{LAUNCH_ACCEL_RST, BURNOUT_ACCEL_RST, APOGEE_MARGIN_RST, MIN_FLIGHT_RST,
                       DROGUE_PULSE_RST, MAIN_ALT_RST, LANDING_ALT_RST, IMPACT_ACCEL_RST};
            phase_r   = PHASE_PAD;
            peak_r    = '0;
            launch_ms = '0;
            apogee_ms = '0;
            drogue_r  = 1'b0;
            main_r    = 1'b0;
            report_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                advance_flight(accel_z, altitude, now_ms);
            if (out_valid && !out_stall)
                check_report();
            pending_results <= report_q.size();
        end
    end

endmodule

// ===== tb/tb_rocket_recovery_deploy_fsm.sv =====
// ----------------------------------------------------------------------------
// Recovery sequencer testbench
// Flies one complete mission through the sequencer: pad, boost, coast, apogee,
// main and touchdown, with the limits reprogrammed between stages to hold
// each phase open for random samples and to probe every threshold edge.
// Both channels idle and stall at random; the flight checker scores results.
// ----------------------------------------------------------------------------
module tb_rocket_recovery_deploy_fsm;

    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [ACCEL_W-1:0] accel_z = '0;
    logic signed [ALT_W-1:0]   altitude = '0;
    logic [TIME_W-1:0]         now_ms = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [PHASE_W-1:0]        flight_phase;
    logic                      drogue_fire;
    logic                      main_fire;
    logic signed [ALT_W-1:0]   peak_altitude;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    int                        fail_count;
    int                        pending_results;

    int                        rx_idle_pct = 0;
    int                        hold_requests = 0;
    int                        holds_done = 0;
    int                        hold_left = 0;
    int                        samples_sent = 0;
    logic [TIME_W-1:0]         mission_ms;

    rocket_recovery_deploy_fsm i_dut (.*);

    rrd_flight_checker i_checker (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_done)
        begin
            out_stall  <= 1'b1;
            holds_done <= holds_done + 1;
            hold_left  <= 80;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic logic signed [ACCEL_W-1:0] pick_accel(input int lo, input int hi);
        return ACCEL_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic signed [ALT_W-1:0] pick_alt(input int lo, input int hi);
        return ALT_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic [TIME_W-1:0] next_ms();
        mission_ms = mission_ms + TIME_W'($urandom_range(1, 250));
        return mission_ms;
    endfunction

    task automatic send_sample(input logic signed [ACCEL_W-1:0] acc,
                               input logic signed [ALT_W-1:0] alt,
                               input logic [TIME_W-1:0] now, input bit eager = 1'b0);
        int tx_pct;
        if (samples_sent < 480)
        begin
            tx_pct = 24;
            rx_idle_pct <= 84;
        end
        else if (samples_sent < 960)
        begin
            tx_pct = 84;
            rx_idle_pct <= 24;
        end
        else
        begin
            tx_pct = 0;
            rx_idle_pct <= 0;
        end
        if (!eager)
        begin
            while ($urandom_range(99) < tx_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        accel_z  <= acc;
        altitude <= alt;
        now_ms   <= now;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
        junk = CFG_DATA_W'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & keep) | (junk & ~keep);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_limits(input cfg_t c);
        write_reg(REG_IMPACT_ACCEL + CFG_IDX_W'(1 + $urandom_range(7)), CFG_DATA_W'($urandom),
                  CFG_DATA_W);
        write_reg(REG_LAUNCH_ACCEL, c.launch_accel, ACCEL_W);
        write_reg(REG_BURNOUT_ACCEL, c.burnout_accel, ACCEL_W);
        write_reg(REG_APOGEE_MARGIN, c.apogee_margin, MARGIN_W);
        write_reg(REG_MIN_FLIGHT, c.min_flight_time, MS_W);
        write_reg(REG_DROGUE_PULSE, c.drogue_pulse_time, MS_W);
        write_reg(REG_MAIN_ALT, c.main_altitude, ALT_W);
        write_reg(REG_LANDING_ALT, c.landing_altitude, ALT_W);
        write_reg(REG_IMPACT_ACCEL, c.impact_accel, ACCEL_W);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cfg_t              lim;
        logic [TIME_W-1:0] launch_at;
        logic [TIME_W-1:0] apogee_at;
        int                coast_top;
        int                alt_now;
        int                margin;
        int                i;

        lim = '{LAUNCH_ACCEL_RST, BURNOUT_ACCEL_RST, APOGEE_MARGIN_RST, MIN_FLIGHT_RST,
                DROGUE_PULSE_RST, MAIN_ALT_RST, LANDING_ALT_RST, IMPACT_ACCEL_RST};
        mission_ms = 32'hFFFF_0000 + TIME_W'($urandom_range(16'hFFFF));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // On the pad with reset limits; launch needs strictly more than the limit.
        send_sample(16'sh8000, 21'sh100000, 32'h0000_0000);
        send_sample(ACCEL_W'(1500), 21'sh0FFFFF, 32'hFFFF_FFFF);
        send_sample(ACCEL_W'(1499), ALT_W'(-100000), next_ms());
        send_sample(ACCEL_W'(-1), ALT_W'(1000000), next_ms());
        send_sample(ACCEL_W'(0), ALT_W'(0), next_ms());
        send_sample(ACCEL_W'(1500), ALT_W'(-1), 32'h8000_0000);
        repeat (6)
            send_sample(pick_accel(-32768, 1500), ALT_W'($urandom), next_ms());
        drain();

        // Launch impossible: every field of every sample is free.
        lim.launch_accel      = 16'sh7FFF;
        lim.burnout_accel     = ACCEL_W'($urandom);
        lim.apogee_margin     = MARGIN_W'($urandom);
        lim.min_flight_time   = MS_W'($urandom);
        lim.drogue_pulse_time = MS_W'($urandom);
        lim.main_altitude     = ALT_W'($urandom);
        lim.landing_altitude  = ALT_W'($urandom);
        lim.impact_accel      = ACCEL_W'($urandom);
        program_limits(lim);
        repeat (250)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom), TIME_W'($urandom));
        drain();

        // Pad up to launch, then a boost that cannot burn out.
        lim.launch_accel  = pick_accel(500, 3000);
        lim.burnout_accel = 16'sh8000;
        lim.apogee_margin = '0;
        program_limits(lim);
        send_sample(lim.launch_accel, ALT_W'($urandom), next_ms());
        repeat (110)
            send_sample(pick_accel(-32768, lim.launch_accel), ALT_W'($urandom), next_ms());
        launch_at = next_ms();
        send_sample(pick_accel(lim.launch_accel + 1, 32767), ALT_W'($urandom), launch_at);
        repeat (150)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom), TIME_W'($urandom));
        drain();

        // Burnout, then a coast held open by the longest minimum flight time.
        lim.burnout_accel   = pick_accel(-200, 1000);
        lim.min_flight_time = 16'hFFFF;
        lim.apogee_margin   = MARGIN_W'($urandom_range(10, 500));
        program_limits(lim);
        send_sample(lim.burnout_accel, ALT_W'($urandom), next_ms());
        repeat (29)
            send_sample(pick_accel(lim.burnout_accel, 32767), ALT_W'($urandom), next_ms());
        send_sample(pick_accel(-32768, lim.burnout_accel - 1), ALT_W'($urandom), next_ms());

        // Below zero the peak stays at its start value.
        send_sample(ACCEL_W'($urandom), 21'sh100000, launch_at + 32'h0000_FFFF);
        repeat (30)
            send_sample(ACCEL_W'($urandom), pick_alt(-1048576, -1),
                        launch_at + TIME_W'($urandom_range(16'hFFFF)));

        coast_top = 0;
        alt_now   = 0;
        for (i = 0; i < 200; i++)
        begin
            if (i == 100)
                hold_requests <= hold_requests + 1;
            alt_now = alt_now + int'($urandom_range(1100)) - 300;
            if ($urandom_range(9) == 0)
                alt_now = alt_now - 2000;
            if (alt_now > coast_top)
                coast_top = alt_now;
            send_sample(ACCEL_W'($urandom), ALT_W'(alt_now),
                        launch_at + TIME_W'($urandom_range(16'hFFFF)), i >= 100 && i < 140);
        end
        repeat (40)
        begin
            alt_now = int'(ALT_W'($urandom)) <<< 11 >>> 11;
            alt_now = int'($signed(ALT_W'(alt_now)));
            if (alt_now > coast_top)
                coast_top = alt_now;
            send_sample(ACCEL_W'($urandom), ALT_W'(alt_now),
                        launch_at + TIME_W'($urandom_range(16'hFFFF)));
        end
        drain();

        // Apogee at the widest margin and no minimum time; the entry step keeps
        // the drogue on even with a zero pulse time.
        lim.apogee_margin     = '1;
        lim.min_flight_time   = '0;
        lim.drogue_pulse_time = '0;
        lim.main_altitude     = 21'sh100000;
        program_limits(lim);
        margin = int'(lim.apogee_margin);
        send_sample(ACCEL_W'($urandom), ALT_W'(coast_top - margin), launch_at + 32'd1);
        send_sample(ACCEL_W'($urandom), ALT_W'(coast_top - margin - 1), launch_at);
        apogee_at = launch_at + TIME_W'($urandom_range(1, 5000));
        send_sample(ACCEL_W'($urandom), ALT_W'(coast_top - margin - 1), apogee_at);
        send_sample(ACCEL_W'($urandom), ALT_W'($urandom), apogee_at);
        drain();

        // Long drogue pulse: on up to the limit, off one millisecond past it.
        lim.drogue_pulse_time = '1;
        program_limits(lim);
        send_sample(ACCEL_W'($urandom), ALT_W'($urandom), apogee_at + 32'h0000_FFFF);
        repeat (80)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom),
                        apogee_at + TIME_W'($urandom_range(16'hFFFF)));
        send_sample(ACCEL_W'($urandom), ALT_W'($urandom), apogee_at + 32'h0001_0000);
        repeat (60)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom), TIME_W'($urandom));
        drain();

        // Main fires below the highest altitude; touchdown held off.
        lim.main_altitude    = 21'sh0FFFFF;
        lim.landing_altitude = 21'sh100000;
        lim.impact_accel     = 16'sh7FFF;
        lim.drogue_pulse_time = MS_W'($urandom);
        program_limits(lim);
        send_sample(ACCEL_W'($urandom), 21'sh0FFFFF, TIME_W'($urandom));
        send_sample(ACCEL_W'($urandom), pick_alt(-1048576, 1048574), TIME_W'($urandom));
        repeat (200)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom), TIME_W'($urandom));
        drain();

        // Touchdown on low altitude or on an impact spike.
        lim.landing_altitude = pick_alt(-1000, 2000);
        lim.impact_accel     = pick_accel(1000, 5000);
        program_limits(lim);
        send_sample(lim.impact_accel, lim.landing_altitude, next_ms());
        if ($urandom_range(1))
            send_sample(pick_accel(-32768, lim.impact_accel),
                        pick_alt(-1048576, lim.landing_altitude - 1), next_ms());
        else
            send_sample(pick_accel(lim.impact_accel + 1, 32767),
                        pick_alt(lim.landing_altitude, 1048575), next_ms());
        repeat (250)
            send_sample(ACCEL_W'($urandom), ALT_W'($urandom), TIME_W'($urandom));
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== rocket_recovery_deploy_fsm.f =====
+incdir+src
src/rrd_pkg.sv
src/rrd_cfg_regs.sv
src/rrd_core.sv
src/rocket_recovery_deploy_fsm.sv
tb/rrd_flight_checker.sv
tb/tb_rocket_recovery_deploy_fsm.sv
